FILE: hdl/bf3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types, sizes and helper functions of the 3x3 RGB box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int SIZE_W = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int LAST_W = (COL_W > ROW_W) ? COL_W : ROW_W;

    // Frame size after reset, in pixels and rows.
    localparam int SIZE_RESET = 1024;

    // Sum of nine channel values and its division by nine.
    localparam int SUM_W       = $clog2(9 * ((1 << PIX_W) - 1) + 1);
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_9     = ((1 << RECIP_SHIFT) + 8) / 9;
    localparam int RECIP_W     = $clog2(RECIP_9 + 1);
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // Bit positions of the results one input pixel can release, in output order.
    localparam int REL_ABOVE       = 0;  // pixel left of input, row above
    localparam int REL_ABOVE_EDGE  = 1;  // right edge pixel, row above
    localparam int REL_BOTTOM      = 2;  // pixel left of input, last row
    localparam int REL_BOTTOM_EDGE = 3;  // right edge pixel, last row
    localparam int REL_N           = 4;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    localparam int PIXEL_W = $bits(t_pixel);

    // Window: three columns (oldest first), each three rows (top first).
    typedef t_pixel [2:0] t_column;
    typedef t_column [2:0] t_window;

    typedef struct packed {
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
    } t_geom;

    typedef struct packed {
        logic              valid;
        logic [REL_N-1:0]  pend;
    } t_release;

    // Index of the last column (row) for a written size: 0 acts as 1, sizes
    // above the maximum act as the maximum.
    function automatic logic [LAST_W-1:0] size_last(input logic [SIZE_W-1:0] size,
                                                    input int unsigned max_size);
        int unsigned eff;
        if (size == '0) begin
            eff = 1;
        end else if (32'(size) > max_size) begin
            eff = max_size;
        end else begin
            eff = 32'(size);
        end
        return LAST_W'(eff - 1);
    endfunction

endpackage

FILE: hdl/bf3_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3 channel interfaces
// Pixel input, filtered result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bf3_pix_if;
    logic                        valid;
    logic                        ready;
    logic [bf3_pkg::PIX_W-1:0]   red_in;
    logic [bf3_pkg::PIX_W-1:0]   green_in;
    logic [bf3_pkg::PIX_W-1:0]   blue_in;

    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface bf3_res_if;
    logic                        valid;
    logic                        ready;
    logic [bf3_pkg::PIX_W-1:0]   red_out;
    logic [bf3_pkg::PIX_W-1:0]   green_out;
    logic [bf3_pkg::PIX_W-1:0]   blue_out;
    logic                        last_of_run;
    logic                        frame_end;

    modport source (output valid, red_out, green_out, blue_out, last_of_run, frame_end,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_of_run, frame_end,
                    output ready);
endinterface

interface bf3_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bf3_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [bf3_pkg::SIZE_W-1:0]      wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: hdl/bf3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bf3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bf3_line_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_line_window
// Frame counters, two line stores and the 3x3 window with edge replication.
// ----------------------------------------------------------------------------
module bf3_line_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bf3_pkg::t_geom     i_geom,
    bf3_pix_if.sink            i_pix,
    output bf3_pkg::t_window   o_win,
    output bf3_pkg::t_release  o_rel,
    input  logic               i_rel_ready
);

    // Position of the next input pixel.
    logic [bf3_pkg::COL_W-1:0] r_x, n_x;
    logic [bf3_pkg::ROW_W-1:0] r_y, n_y;

    // Window stage: the accepted pixel and its position flags.
    logic                      r_b_valid;
    bf3_pkg::t_pixel           r_b_pix;
    logic [bf3_pkg::COL_W-1:0] r_b_x;
    logic                      r_b_x_nz;
    logic                      r_b_y_ge1;
    logic                      r_b_y_ge2;
    logic                      r_b_lc;
    logic                      r_b_lr;

    // Bypass for a store read that collides with the write of the previous pixel.
    logic                      r_fwd;
    bf3_pkg::t_pixel           r_fwd_mid;
    bf3_pkg::t_pixel           r_fwd_cur;

    bf3_pkg::t_window          r_win, n_win;

    logic [bf3_pkg::PIXEL_W-1:0] older_q, newer_q;
    bf3_pkg::t_pixel           mid, old, rb, ra, in_pix;
    logic [bf3_pkg::REL_N-1:0] pend;
    logic                      lc, lr;
    logic                      b_adv, ready, accept;

    always_comb begin
        in_pix = '{red: i_pix.red_in, green: i_pix.green_in, blue: i_pix.blue_in};

        mid = r_fwd ? r_fwd_cur : bf3_pkg::t_pixel'(newer_q);
        old = r_fwd ? r_fwd_mid : bf3_pkg::t_pixel'(older_q);
        rb  = r_b_y_ge1 ? mid : r_b_pix;
        ra  = r_b_y_ge2 ? old : rb;

        n_win = r_win;
        if (!r_b_x_nz) begin
            for (int c = 0; c < 3; c++) begin
                n_win[c] = '{r_b_pix, rb, ra};
            end
        end else begin
            n_win[0] = r_win[1];
            n_win[1] = r_win[2];
            n_win[2] = '{r_b_pix, rb, ra};
        end

        pend = '0;
        pend[bf3_pkg::REL_ABOVE]       = r_b_y_ge1 & r_b_x_nz;
        pend[bf3_pkg::REL_ABOVE_EDGE]  = r_b_y_ge1 & r_b_lc;
        pend[bf3_pkg::REL_BOTTOM]      = r_b_lr & r_b_x_nz;
        pend[bf3_pkg::REL_BOTTOM_EDGE] = r_b_lr & r_b_lc;

        // Hold the window while earlier results still read it.
        b_adv  = r_b_valid && i_rel_ready;
        ready  = !r_b_valid || b_adv;
        accept = i_pix.valid && ready;

        lc = (r_x >= i_geom.col_last);
        lr = (r_y >= i_geom.row_last);

        n_x = r_x;
        n_y = r_y;
        if (lc) begin
            n_x = '0;
            n_y = lr ? '0 : r_y + 1'b1;
        end else begin
            n_x = r_x + 1'b1;
        end
    end

    assign i_pix.ready = ready;
    assign o_win       = r_win;
    assign o_rel       = '{valid: b_adv && (pend != '0), pend: pend};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (accept) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_fwd <= b_adv && (r_b_x == r_x);
            end
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix   <= in_pix;
            r_b_x     <= r_x;
            r_b_x_nz  <= (r_x != '0);
            r_b_y_ge1 <= (r_y != '0);
            r_b_y_ge2 <= (r_y > bf3_pkg::ROW_W'(1));
            r_b_lc    <= lc;
            r_b_lr    <= lr;
            r_fwd_mid <= mid;
            r_fwd_cur <= r_b_pix;
        end
        if (b_adv) begin
            r_win <= n_win;
        end
    end

    bf3_ram #(
        .WIDTH (bf3_pkg::PIXEL_W),
        .DEPTH (bf3_pkg::MAX_WIDTH)
    ) u_older_row (
        .i_clk   (i_clk),
        .i_we    (b_adv),
        .i_waddr (r_b_x),
        .i_wdata (mid),
        .i_re    (accept),
        .i_raddr (r_x),
        .o_rdata (older_q)
    );

    bf3_ram #(
        .WIDTH (bf3_pkg::PIXEL_W),
        .DEPTH (bf3_pkg::MAX_WIDTH)
    ) u_newer_row (
        .i_clk   (i_clk),
        .i_we    (b_adv),
        .i_waddr (r_b_x),
        .i_wdata (r_b_pix),
        .i_re    (accept),
        .i_raddr (r_x),
        .o_rdata (newer_q)
    );

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_b_valid)
        else $error("accepted pixel did not reach the window stage");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_b_valid) |-> b_adv)
        else $error("window stage overwritten before it advanced");
`endif

endmodule

FILE: hdl/bf3_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf3_emit
// Steps through the released results, averages the window, drives the output.
// ----------------------------------------------------------------------------
module bf3_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bf3_pkg::t_window   i_win,
    input  bf3_pkg::t_release  i_rel,
    output logic               o_rel_ready,
    bf3_res_if.source          o_res
);

    logic [bf3_pkg::REL_N-1:0] r_pend, n_pend, sel, rest;
    logic                      r_valid;
    logic [bf3_pkg::PIX_W-1:0] r_red, r_green, r_blue;
    logic                      r_last, r_fend;

    logic                      emit, col_sh, row_sh;
    logic [1:0]                col_src [3];
    logic [1:0]                row_src [3];
    bf3_pkg::t_pixel           px;
    logic [bf3_pkg::SUM_W-1:0] col_red [3];
    logic [bf3_pkg::SUM_W-1:0] col_grn [3];
    logic [bf3_pkg::SUM_W-1:0] col_blu [3];
    logic [bf3_pkg::SUM_W-1:0] sum_red, sum_grn, sum_blu;
    logic [bf3_pkg::PROD_W-1:0] prod_red, prod_grn, prod_blu;

    always_comb begin
        sel    = r_pend & (~r_pend + 1'b1);
        rest   = r_pend & ~sel;
        emit   = (r_pend != '0) && (!r_valid || o_res.ready);
        col_sh = sel[bf3_pkg::REL_ABOVE_EDGE] | sel[bf3_pkg::REL_BOTTOM_EDGE];
        row_sh = sel[bf3_pkg::REL_BOTTOM] | sel[bf3_pkg::REL_BOTTOM_EDGE];

        // Replicate the right column and the bottom row at the frame edges.
        for (int k = 0; k < 3; k++) begin
            col_src[k] = (col_sh && k != 2) ? 2'(k + 1) : 2'(k);
            row_src[k] = (row_sh && k != 2) ? 2'(k + 1) : 2'(k);
        end

        for (int c = 0; c < 3; c++) begin
            col_red[c] = '0;
            col_grn[c] = '0;
            col_blu[c] = '0;
            for (int r = 0; r < 3; r++) begin
                px = i_win[col_src[c]][row_src[r]];
                col_red[c] = col_red[c] + bf3_pkg::SUM_W'(px.red);
                col_grn[c] = col_grn[c] + bf3_pkg::SUM_W'(px.green);
                col_blu[c] = col_blu[c] + bf3_pkg::SUM_W'(px.blue);
            end
        end
        sum_red = col_red[0] + col_red[1] + col_red[2];
        sum_grn = col_grn[0] + col_grn[1] + col_grn[2];
        sum_blu = col_blu[0] + col_blu[1] + col_blu[2];

        // Divide by nine: multiply by the rounded-up reciprocal, exact for these sums.
        prod_red = bf3_pkg::PROD_W'(sum_red) * bf3_pkg::PROD_W'(bf3_pkg::RECIP_9);
        prod_grn = bf3_pkg::PROD_W'(sum_grn) * bf3_pkg::PROD_W'(bf3_pkg::RECIP_9);
        prod_blu = bf3_pkg::PROD_W'(sum_blu) * bf3_pkg::PROD_W'(bf3_pkg::RECIP_9);

        o_rel_ready = (r_pend == '0) || (emit && (rest == '0));

        n_pend = r_pend;
        if (i_rel.valid) begin
            n_pend = i_rel.pend;
        end else if (emit) begin
            n_pend = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (emit) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_red   <= prod_red[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIX_W];
            r_green <= prod_grn[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIX_W];
            r_blue  <= prod_blu[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIX_W];
            r_last  <= (rest == '0);
            r_fend  <= sel[bf3_pkg::REL_BOTTOM_EDGE];
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.red_out     = r_red;
    assign o_res.green_out   = r_green;
    assign o_res.blue_out    = r_blue;
    assign o_res.last_of_run = r_last;
    assign o_res.frame_end   = r_fend;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rel.valid |-> o_rel_ready)
        else $error("new release loaded while results still pending");

    a_fend_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_fend) |-> r_last)
        else $error("frame end result not marked last of its run");
`endif

endmodule

FILE: hdl/box_filter_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb
// Streaming 3x3 box filter on RGB pixels with border replication.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix  - raster-order RGB pixels, valid/ready; a transfer moves one pixel.
//   o_res  - filtered pixels in raster order, one row and one pixel behind the
//            input. last_of_run closes the results of one input pixel;
//            frame_end flags the bottom-right output of the frame.
//   i_cfg  - register writes (image_width, image_height), always ready. Write
//            only while the filter is idle.
// Path: a result passes the window stage, the window and pending-result
//   registers and the output register before it appears on o_res.
// Throughput: one pixel per cycle while o_res.ready stays high. The single
//   averaging unit emits one result per cycle, so a pixel that releases k
//   results holds the window, and the next pixel waits until the last of
//   them is taken: from the second row on the last pixel of a row releases
//   2 (1 at width 1), a pixel of the last row releases 2 (1 in a one-row
//   frame), the final pixel of the frame up to 4.
// Reset: counters restart at the top-left pixel, size registers return to
//   1024 x 1024; line stores need no clearing pass.
// Stall: the output register holds its result while o_res.ready is low; the
//   pending results and the window stage then hold and i_pix.ready drops.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bf3_cfg_if.sink    i_cfg,
    bf3_pix_if.sink    i_pix,
    bf3_res_if.source  o_res
);

    // Last column and last row index, clamped when written.
    logic [bf3_pkg::COL_W-1:0] r_col_last;
    logic [bf3_pkg::ROW_W-1:0] r_row_last;
    logic [bf3_pkg::LAST_W-1:0] wr_last_col, wr_last_row;

    bf3_pkg::t_geom    geom;
    bf3_pkg::t_window  win;
    bf3_pkg::t_release rel;
    logic              rel_ready;

    // Configuration is taken in every cycle.
    assign i_cfg.ready = 1'b1;

    assign wr_last_col = bf3_pkg::size_last(i_cfg.wr_data, bf3_pkg::MAX_WIDTH);
    assign wr_last_row = bf3_pkg::size_last(i_cfg.wr_data, bf3_pkg::MAX_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= bf3_pkg::COL_W'(bf3_pkg::size_last(
                              bf3_pkg::SIZE_W'(bf3_pkg::SIZE_RESET), bf3_pkg::MAX_WIDTH));
            r_row_last <= bf3_pkg::ROW_W'(bf3_pkg::size_last(
                              bf3_pkg::SIZE_W'(bf3_pkg::SIZE_RESET), bf3_pkg::MAX_HEIGHT));
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                bf3_pkg::CFG_IMAGE_WIDTH: begin
                    r_col_last <= wr_last_col[bf3_pkg::COL_W-1:0];
                end
                bf3_pkg::CFG_IMAGE_HEIGHT: begin
                    r_row_last <= wr_last_row[bf3_pkg::ROW_W-1:0];
                end
                default: begin
                    // hold
                end
            endcase
        end
    end

    assign geom = '{col_last: r_col_last, row_last: r_row_last};

    // Pixel side: counters, line stores and the window shift.
    bf3_line_window u_line_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_pix       (i_pix),
        .o_win       (win),
        .o_rel       (rel),
        .i_rel_ready (rel_ready)
    );

    // Result side: one average per cycle into the output register, held while o_res stalls.
    bf3_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win       (win),
        .i_rel       (rel),
        .o_rel_ready (rel_ready),
        .o_res       (o_res)
    );

endmodule

FILE: tb/tb_box_filter_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_rgb
// Self-checking bench for the streaming 3x3 RGB box filter. A queue of
// pending operations (pixels, size writes, drain points) feeds a clocked
// driver. A clocked monitor runs a bit-exact filter predictor on every pixel
// transfer and checks each result transfer, field by field, against the
// oldest predicted pixel. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_rgb;

    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 10;
    localparam int          SETTLE_CYCLES = 8;     // margin for the output to drain
    localparam int unsigned LIMIT_CYCLES  = 1000000;
    localparam int          RANDOM_ITEMS  = 120;
    localparam int          MAX_WAIT      = 6;
    localparam int          WINDOW_PIXELS = 9;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_WRITE,
        OP_DRAIN
    } t_feed_kind;

    typedef struct packed {
        t_feed_kind                 kind;
        bf3_pkg::t_pixel            pix;
        bf3_pkg::t_cfg_reg          reg_idx;
        logic [bf3_pkg::SIZE_W-1:0] data;
    } t_feed_op;

    typedef struct packed {
        logic [bf3_pkg::PIX_W-1:0] red;
        logic [bf3_pkg::PIX_W-1:0] green;
        logic [bf3_pkg::PIX_W-1:0] blue;
        logic                      last_of_run;
        logic                      frame_end;
    } t_filt_result;

    // ------------------------------------------------------------------------
    // Clock, reset and channels
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    bf3_cfg_if cfg_if ();
    bf3_pix_if pix_if ();
    bf3_res_if res_if ();

    box_filter_3x3_rgb uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------------
    // Predictor state: line stores, window, raster position and size registers
    // ------------------------------------------------------------------------
    bf3_pkg::t_pixel            older_row [bf3_pkg::MAX_WIDTH];
    bf3_pkg::t_pixel            newer_row [bf3_pkg::MAX_WIDTH];
    bf3_pkg::t_pixel            win_cols  [3][3];  // [column oldest first][row top first]
    int unsigned                col_pos;
    int unsigned                row_pos;
    logic [bf3_pkg::SIZE_W-1:0] width_reg;
    logic [bf3_pkg::SIZE_W-1:0] height_reg;

    t_filt_result      filtered_q [$];         // predicted pixels not yet seen on o_res

    // Stimulus plan and the generator's own view of the raster position
    t_feed_op          feed_q [$];
    int unsigned       gen_x, gen_y, gen_w, gen_h;

    // Bookkeeping
    int unsigned cycle_cnt   = 0;
    int unsigned xfer_cnt    = 0;   // pixel and register transfers seen
    int unsigned res_cnt     = 0;   // result transfers seen
    int unsigned pixels_in   = 0;
    int unsigned writes_done = 0;
    int unsigned frame_ends  = 0;
    int unsigned mid_changes = 0;
    int unsigned err_cnt     = 0;

    // Driver state
    bit          drv_busy    = 1'b0;
    t_feed_kind  drv_kind    = OP_PIXEL;
    int unsigned drv_issued  = 0;
    int          drv_gap     = 0;
    int          drv_calm    = 0;
    bit          draining    = 1'b0;
    int          settle_left = 0;

    // Sink state
    int unsigned sink_seen = 0;
    int          sink_wait = 0;
    int          sink_calm = 0;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Written size to effective size: 0 acts as 1, too large clamps to max.
    function automatic int unsigned effective_size(input logic [bf3_pkg::SIZE_W-1:0] v,
                                                   input int unsigned maxv);
        if (v == '0) begin
            return 1;
        end
        if (32'(v) > maxv) begin
            return maxv;
        end
        return 32'(v);
    endfunction

    // Wait before the next transfer, 0..MAX_WAIT, with stretches of no idling.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic bf3_pkg::t_pixel rand_pixel();
        bf3_pkg::t_pixel p;
        p = bf3_pkg::t_pixel'(bf3_pkg::PIXEL_W'($urandom));
        // Bias some pixels toward the channel extremes.
        if ($urandom_range(0, 7) == 0) begin
            p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    // Truncated mean of nine window pixels per channel.
    function automatic t_filt_result window_mean(input int c0, c1, c2,
                                                 input int r0, r1, r2,
                                                 input bit fend);
        int           cs [3];
        int           rs [3];
        int unsigned  sr, sg, sb;
        t_filt_result res;
        cs = '{c0, c1, c2};
        rs = '{r0, r1, r2};
        sr = 0;
        sg = 0;
        sb = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sr += win_cols[cs[i]][rs[j]].red;
                sg += win_cols[cs[i]][rs[j]].green;
                sb += win_cols[cs[i]][rs[j]].blue;
            end
        end
        res.red         = bf3_pkg::PIX_W'(sr / WINDOW_PIXELS);
        res.green       = bf3_pkg::PIX_W'(sg / WINDOW_PIXELS);
        res.blue        = bf3_pkg::PIX_W'(sb / WINDOW_PIXELS);
        res.last_of_run = 1'b0;
        res.frame_end   = fend;
        return res;
    endfunction

    // Advance the predictor by one input pixel and queue what it releases.
    task automatic box_filter_step(input bf3_pkg::t_pixel cur);
        int unsigned     w, h, x, y;
        bf3_pkg::t_pixel mid, old, rb, ra;
        bit              last_col, last_row;
        t_filt_result    run [$];
        w = effective_size(width_reg, bf3_pkg::MAX_WIDTH);
        h = effective_size(height_reg, bf3_pkg::MAX_HEIGHT);
        x = (col_pos >= bf3_pkg::MAX_WIDTH) ? bf3_pkg::MAX_WIDTH - 1 : col_pos;
        y = row_pos;

        // Rotate the column through both line stores.
        mid          = newer_row[x];
        old          = older_row[x];
        older_row[x] = mid;
        newer_row[x] = cur;

        // Replicate the top border for the first two rows.
        rb = (y >= 1) ? mid : cur;
        ra = (y >= 2) ? old : rb;

        if (x == 0) begin
            // Left border: fill all three columns with the first column.
            for (int i = 0; i < 3; i++) begin
                win_cols[i][0] = ra;
                win_cols[i][1] = rb;
                win_cols[i][2] = cur;
            end
        end else begin
            for (int i = 0; i < 2; i++) begin
                win_cols[i] = win_cols[i + 1];
            end
            win_cols[2][0] = ra;
            win_cols[2][1] = rb;
            win_cols[2][2] = cur;
        end

        last_col = (x >= w - 1);
        last_row = (y >= h - 1);

        // Row above: pixel left of the input, then the right edge.
        if (y >= 1) begin
            if (x >= 1) begin
                run.push_back(window_mean(0, 1, 2, 0, 1, 2, 1'b0));
            end
            if (last_col) begin
                run.push_back(window_mean(1, 2, 2, 0, 1, 2, 1'b0));
            end
        end
        // Last row: its own outputs with the bottom border replicated.
        if (last_row) begin
            if (x >= 1) begin
                run.push_back(window_mean(0, 1, 2, 1, 2, 2, 1'b0));
            end
            if (last_col) begin
                run.push_back(window_mean(1, 2, 2, 1, 2, 2, 1'b1));
            end
        end
        if (run.size() > 0) begin
            run[run.size() - 1].last_of_run = 1'b1;
        end
        foreach (run[i]) begin
            filtered_q.push_back(run[i]);
        end

        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
        end
    endtask

    task automatic flag_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [bf3_pkg::PIX_W-1:0] got,
                               input logic [bf3_pkg::PIX_W-1:0] want);
        if (got !== want) begin
            flag_error($sformatf("result %0d %s: got %0d, expected %0d",
                                 res_cnt, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Plan builders: keep the generator's raster position in step
    // ------------------------------------------------------------------------
    task automatic plan_pixel(input bf3_pkg::t_pixel p);
        t_feed_op op;
        op         = '0;
        op.kind    = OP_PIXEL;
        op.pix     = p;
        feed_q.push_back(op);
        if (gen_x >= gen_w - 1) begin
            gen_x = 0;
            gen_y = (gen_y >= gen_h - 1) ? 0 : gen_y + 1;
        end else begin
            gen_x++;
        end
    endtask

    task automatic plan_drain();
        t_feed_op op;
        op      = '0;
        op.kind = OP_DRAIN;
        feed_q.push_back(op);
    endtask

    // Every register write is preceded by a drain so the filter is idle.
    task automatic plan_write(input bf3_pkg::t_cfg_reg idx, input int unsigned value);
        t_feed_op op;
        plan_drain();
        op         = '0;
        op.kind    = OP_WRITE;
        op.reg_idx = idx;
        op.data    = bf3_pkg::SIZE_W'(value);
        feed_q.push_back(op);
        if (idx == bf3_pkg::CFG_IMAGE_WIDTH) begin
            gen_w = effective_size(op.data, bf3_pkg::MAX_WIDTH);
        end else begin
            gen_h = effective_size(op.data, bf3_pkg::MAX_HEIGHT);
        end
    endtask

    task automatic plan_size(input int unsigned w, input int unsigned h);
        plan_write(bf3_pkg::CFG_IMAGE_WIDTH, w);
        plan_write(bf3_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    // Random pixels until the frame wraps.
    task automatic plan_frame_rest();
        do begin
            plan_pixel(rand_pixel());
        end while (!(gen_x == 0 && gen_y == 0));
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample transfers at the rising edge, predict and check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : transfer_monitor
        t_filt_result want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (filtered_q.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with nothing predicted",
                                         res_cnt));
                end else begin
                    want = filtered_q.pop_front();
                    check_field("red_out", res_if.red_out, want.red);
                    check_field("green_out", res_if.green_out, want.green);
                    check_field("blue_out", res_if.blue_out, want.blue);
                    check_field("last_of_run", bf3_pkg::PIX_W'(res_if.last_of_run),
                                bf3_pkg::PIX_W'(want.last_of_run));
                    check_field("frame_end", bf3_pkg::PIX_W'(res_if.frame_end),
                                bf3_pkg::PIX_W'(want.frame_end));
                    if (want.frame_end) begin
                        frame_ends++;
                    end
                end
                res_cnt++;
            end
            // Size writes take effect at once.
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.reg_index == bf3_pkg::CFG_IMAGE_WIDTH) begin
                    width_reg = cfg_if.wr_data;
                end else begin
                    height_reg = cfg_if.wr_data;
                end
                writes_done++;
                xfer_cnt++;
            end
            if (pix_if.valid && pix_if.ready) begin
                box_filter_step({pix_if.red_in, pix_if.green_in, pix_if.blue_in});
                pixels_in++;
                xfer_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change inputs at the falling edge, one assignment per signal
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : feed_driver
        t_feed_op op;
        bit       launch;
        if (i_rst_n) begin
            launch = 1'b0;
            op     = '0;
            // Retire the transfer seen at the last rising edge.
            if (drv_busy && xfer_cnt == drv_issued) begin
                drv_busy = 1'b0;
                drv_gap  = draw_wait(drv_calm);
            end
            if (!drv_busy) begin
                if (draining) begin
                    // Hold off until every predicted pixel is out, then settle.
                    if (filtered_q.size() != 0) begin
                        settle_left = SETTLE_CYCLES;
                    end else if (settle_left > 0) begin
                        settle_left--;
                    end else begin
                        draining = 1'b0;
                    end
                end else if (drv_gap > 0) begin
                    drv_gap--;
                end else if (feed_q.size() > 0) begin
                    op = feed_q.pop_front();
                    if (op.kind == OP_DRAIN) begin
                        draining    = 1'b1;
                        settle_left = SETTLE_CYCLES;
                    end else begin
                        launch   = 1'b1;
                        drv_busy = 1'b1;
                        drv_kind = op.kind;
                        drv_issued++;
                    end
                end
            end
            pix_if.valid <= drv_busy && (drv_kind == OP_PIXEL);
            cfg_if.valid <= drv_busy && (drv_kind == OP_WRITE);
            if (launch && op.kind == OP_PIXEL) begin
                pix_if.red_in   <= op.pix.red;
                pix_if.green_in <= op.pix.green;
                pix_if.blue_in  <= op.pix.blue;
            end
            if (launch && op.kind == OP_WRITE) begin
                cfg_if.reg_index <= op.reg_idx;
                cfg_if.wr_data   <= op.data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: stall a random number of cycles after each transfer
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_sink
        if (i_rst_n) begin
            if (res_cnt != sink_seen) begin
                sink_seen = res_cnt;
                sink_wait = draw_wait(sink_calm);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Plan, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned     random_items;
        int unsigned     waited;
        bf3_pkg::t_pixel px;

        // Known values on every input from time zero.
        i_rst_n          = 1'b0;
        pix_if.valid     = 1'b0;
        pix_if.red_in    = '0;
        pix_if.green_in  = '0;
        pix_if.blue_in   = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = '0;
        cfg_if.wr_data   = '0;
        res_if.ready     = 1'b0;

        // Predictor after reset.
        foreach (older_row[i]) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        foreach (win_cols[i, j]) begin
            win_cols[i][j] = '0;
        end
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = bf3_pkg::SIZE_W'(bf3_pkg::SIZE_RESET);
        height_reg = bf3_pkg::SIZE_W'(bf3_pkg::SIZE_RESET);

        gen_x = 0;
        gen_y = 0;
        gen_w = bf3_pkg::SIZE_RESET;
        gen_h = bf3_pkg::SIZE_RESET;

        // Directed: 3x3 frame of alternating black and white, one mixed pixel.
        plan_size(3, 3);
        for (int i = 0; i < 9; i++) begin
            px = (i % 2 == 0) ? {8'hFF, 8'hFF, 8'hFF} : '0;
            if (i == 4) begin
                px = {8'hFF, 8'h00, 8'h80};
            end
            plan_pixel(px);
        end
        // Zero width acts as one: single-pixel frame.
        plan_size(0, 1);
        plan_pixel({8'hFF, 8'hFF, 8'hFF});
        // One row of two, then one column of three.
        plan_size(2, 1);
        plan_pixel({8'hFF, 8'h00, 8'hFF});
        plan_pixel({8'h00, 8'hFF, 8'h00});
        plan_size(1, 3);
        plan_pixel({8'h00, 8'h00, 8'h00});
        plan_pixel({8'hFF, 8'hFF, 8'hFF});
        plan_pixel({8'h01, 8'hFE, 8'h7F});

        // Size extremes: start a frame at full or oversized width or height,
        // then shrink the size so the frame closes after a few pixels.
        plan_size(bf3_pkg::MAX_WIDTH, 2);
        repeat (4) plan_pixel(rand_pixel());
        plan_write(bf3_pkg::CFG_IMAGE_WIDTH, 4);
        plan_frame_rest();
        plan_size(1, bf3_pkg::MAX_HEIGHT);
        repeat (5) plan_pixel(rand_pixel());
        plan_write(bf3_pkg::CFG_IMAGE_HEIGHT, 6);
        plan_frame_rest();
        plan_size(2047, 0);
        repeat (3) plan_pixel(rand_pixel());
        plan_write(bf3_pkg::CFG_IMAGE_WIDTH, 2);
        plan_frame_rest();
        plan_size(2, 2047);
        repeat (6) plan_pixel(rand_pixel());
        plan_write(bf3_pkg::CFG_IMAGE_HEIGHT, 4);
        plan_frame_rest();

        // Random frames: small sizes, repeated frames to exercise the wrap,
        // and size changes in the middle of a frame (width only shrinks).
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                plan_write(bf3_pkg::CFG_IMAGE_WIDTH,
                           ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9));
                plan_write(bf3_pkg::CFG_IMAGE_HEIGHT,
                           ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
            end
            do begin
                plan_pixel(rand_pixel());
                random_items++;
                if (!(gen_x == 0 && gen_y == 0)) begin
                    case ($urandom_range(0, 15))
                        0: begin
                            if (gen_w > 1) begin
                                plan_write(bf3_pkg::CFG_IMAGE_WIDTH,
                                           $urandom_range(1, gen_w - 1));
                                mid_changes++;
                            end
                        end
                        1: begin
                            plan_write(bf3_pkg::CFG_IMAGE_HEIGHT, $urandom_range(1, 8));
                            mid_changes++;
                        end
                        2: plan_drain();
                        default: ;
                    endcase
                end
            end while (!(gen_x == 0 && gen_y == 0));
        end

        // Single reset at the start of the run.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until the plan is fully transferred.
        while (feed_q.size() != 0 || drv_busy || draining) @(posedge i_clk);

        // Drain the remaining results, bounded, then let the pipeline settle.
        waited = 0;
        while (filtered_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (filtered_q.size() != 0) begin
            flag_error($sformatf("%0d predicted results never arrived", filtered_q.size()));
        end

        $display("Run covered %0d pixels, %0d filtered results, %0d frame ends,",
                 pixels_in, res_cnt, frame_ends);
        $display("%0d size writes (%0d mid-frame), sizes from 1x1 up to 1024 wide/tall.",
                 writes_done, mid_changes);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
